>>> sv/rhw_pkg.sv
// Shared types, constants and tables for the rolling hash winnowing block.
`timescale 1ns / 1ps

package rhw_pkg;

    localparam int unsigned MAX_KGRAM   = 64;
    localparam int unsigned MAX_WINDOW  = 64;
    localparam int unsigned MAX_LINE    = 4096;
    localparam int unsigned KIDX_W      = $clog2(MAX_KGRAM);
    localparam int unsigned WIDX_W      = $clog2(MAX_WINDOW);
    localparam int unsigned POS_W       = $clog2(MAX_LINE);
    localparam int unsigned LINE_W      = POS_W + 1;
    localparam int unsigned LCNT_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned HASH_W      = 7;
    localparam int unsigned CFG_W       = 7;
    localparam int unsigned CFG_INDEX_W = 4;

    localparam int unsigned HASH_BASE    = 256;
    localparam int unsigned HASH_MOD     = 101;
    localparam int unsigned BASE_RESIDUE = HASH_BASE % HASH_MOD;
    localparam int unsigned SUM_W        = 15;
    localparam int unsigned RECIP_SHIFT  = 20;
    localparam int unsigned RECIP        = (2 ** RECIP_SHIFT) / HASH_MOD;
    localparam int unsigned RECIP_W      = 14;
    localparam int unsigned PROD_W       = SUM_W + RECIP_W;
    localparam int unsigned QUOT_W       = PROD_W - RECIP_SHIFT;
    localparam int unsigned REM_W        = 8;

    localparam logic [CFG_W-1:0] DEFAULT_KGRAM  = CFG_W'(5);
    localparam logic [CFG_W-1:0] DEFAULT_WINDOW = CFG_W'(4);

    localparam logic [CFG_INDEX_W-1:0] CFG_KGRAM_LENGTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              line_end;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] fingerprint;
        logic [POS_W-1:0]  gram_position;
        logic [LCNT_W-1:0] line_number;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic [BYTE_W-1:0] text_byte;
        logic [POS_W-1:0]  pos;
        logic [CFG_W-1:0]  kgram;
        logic [HASH_W-1:0] neg_weight;
    } hash_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] hash;
    } hash_rsp_t;

    typedef struct packed {
        logic              start;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  last;
        logic              wr_en;
        logic [WIDX_W-1:0] wr_addr;
        logic [HASH_W-1:0] wr_data;
    } scan_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] min_hash;
        logic [POS_W-1:0]  min_pos;
    } scan_rsp_t;

    // entry i: (-256^(i+1)) mod 101, the weight of the byte leaving a k-gram of i+1 bytes
    typedef logic [HASH_W-1:0] weight_table_t [MAX_KGRAM];

    function automatic weight_table_t build_neg_weights();
        weight_table_t t;
        int unsigned p;
        p = 1;
        for (int i = 0; i < MAX_KGRAM; i++) begin
            p = (p * HASH_BASE) % HASH_MOD;
            t[i] = HASH_W'((HASH_MOD - p) % HASH_MOD);
        end
        return t;
    endfunction

    localparam weight_table_t NEG_WEIGHT = build_neg_weights();

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int unsigned top);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (32'(v) > top) begin
            r = CFG_W'(top);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> sv/rhw_hash.sv
// Rolling hash unit: byte ring and a three-step modulo-101 reduction.
`timescale 1ns / 1ps

module rhw_hash (
    input  logic              aclk,
    input  logic              aresetn,
    input  rhw_pkg::hash_req_t req,
    output rhw_pkg::hash_rsp_t rsp
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SUM  = 4'b0010,
        PH_QUOT = 4'b0100,
        PH_REM  = 4'b1000
    } phase_t;

    phase_t phase_reg, phase_next;

    logic [rhw_pkg::BYTE_W-1:0] byte_ring [rhw_pkg::MAX_KGRAM];

    logic [rhw_pkg::BYTE_W-1:0] byte_reg;
    logic [rhw_pkg::BYTE_W-1:0] old_reg;
    logic                       use_old_reg;
    logic [rhw_pkg::SUM_W-1:0]  sum_reg;
    logic [rhw_pkg::QUOT_W-1:0] quot_reg;
    logic [rhw_pkg::HASH_W-1:0] hash_reg, hash_next;

    logic [rhw_pkg::KIDX_W-1:0] rd_addr;
    logic [rhw_pkg::SUM_W-1:0]  roll_term;
    logic [rhw_pkg::SUM_W-1:0]  old_term;
    logic [rhw_pkg::SUM_W-1:0]  sum_calc;
    logic [rhw_pkg::PROD_W-1:0] prod;
    logic [rhw_pkg::SUM_W-1:0]  back;
    logic [rhw_pkg::SUM_W-1:0]  diff;
    logic [rhw_pkg::REM_W-1:0]  rem;
    logic [rhw_pkg::HASH_W-1:0] hash_calc;

    assign rd_addr = req.pos[rhw_pkg::KIDX_W-1:0] - req.kgram[rhw_pkg::KIDX_W-1:0];

    // rh*256 + b - old*256^k, all mod 101
    assign roll_term = rhw_pkg::SUM_W'(hash_reg) * rhw_pkg::SUM_W'(rhw_pkg::BASE_RESIDUE);
    assign old_term  = use_old_reg ?
                       rhw_pkg::SUM_W'(old_reg) * rhw_pkg::SUM_W'(req.neg_weight) : '0;
    assign sum_calc  = roll_term + rhw_pkg::SUM_W'(byte_reg) + old_term;

    assign prod = rhw_pkg::PROD_W'(sum_reg) * rhw_pkg::PROD_W'(rhw_pkg::RECIP);

    assign back = rhw_pkg::SUM_W'(quot_reg) * rhw_pkg::SUM_W'(rhw_pkg::HASH_MOD);
    assign diff = sum_reg - back;
    assign rem  = diff[rhw_pkg::REM_W-1:0];
    assign hash_calc = (32'(rem) >= rhw_pkg::HASH_MOD) ?
                       rhw_pkg::HASH_W'(rem - rhw_pkg::REM_W'(rhw_pkg::HASH_MOD)) :
                       rhw_pkg::HASH_W'(rem);

    always_comb begin
        phase_next = phase_reg;
        hash_next  = hash_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (req.start) begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:  phase_next = PH_QUOT;
            PH_QUOT: phase_next = PH_REM;
            PH_REM: begin
                phase_next = PH_IDLE;
                hash_next  = hash_calc;
            end
            default: phase_next = PH_IDLE;
        endcase
        if (req.clear) begin
            hash_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hash_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            byte_ring[req.pos[rhw_pkg::KIDX_W-1:0]] <= req.text_byte;
            old_reg     <= byte_ring[rd_addr];
            byte_reg    <= req.text_byte;
            use_old_reg <= req.pos >= rhw_pkg::POS_W'(req.kgram);
        end
        if (phase_reg == PH_SUM) begin
            sum_reg <= sum_calc;
        end
        if (phase_reg == PH_QUOT) begin
            quot_reg <= prod[rhw_pkg::PROD_W-1:rhw_pkg::RECIP_SHIFT];
        end
    end

    assign rsp.done = (phase_reg == PH_REM);
    assign rsp.hash = hash_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> phase_reg == PH_IDLE)
        else $error("hash start while busy");
`endif

endmodule

>>> sv/rhw_scan.sv
// Hash ring and shared compare unit: rightmost minimum over a range, one entry a cycle.
`timescale 1ns / 1ps

module rhw_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  rhw_pkg::scan_req_t req,
    output rhw_pkg::scan_rsp_t rsp
);

    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_RUN  = 3'b010,
        SC_TAIL = 3'b100
    } scan_state_t;

    scan_state_t state_reg, state_next;

    logic [rhw_pkg::HASH_W-1:0] hash_ring [rhw_pkg::MAX_WINDOW];

    logic [rhw_pkg::POS_W-1:0]  cursor_reg, cursor_next;
    logic [rhw_pkg::POS_W-1:0]  last_reg, last_next;
    logic [rhw_pkg::POS_W-1:0]  rd_pos_reg;
    logic [rhw_pkg::HASH_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic                       first_reg, first_next;
    logic                       done_reg, done_next;
    logic [rhw_pkg::HASH_W-1:0] min_reg, min_next;
    logic [rhw_pkg::POS_W-1:0]  min_pos_reg, min_pos_next;
    logic                       take;

    assign take = rd_valid_reg && (first_reg || (rd_data_reg <= min_reg));

    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        last_next    = last_reg;
        first_next   = first_reg;
        done_next    = 1'b0;
        min_next     = min_reg;
        min_pos_next = min_pos_reg;
        if (take) begin
            min_next     = rd_data_reg;
            min_pos_next = rd_pos_reg;
            first_next   = 1'b0;
        end
        unique case (state_reg)
            SC_IDLE: begin
                if (req.start) begin
                    state_next  = SC_RUN;
                    cursor_next = req.first;
                    last_next   = req.last;
                    first_next  = 1'b1;
                end
            end
            SC_RUN: begin
                cursor_next = cursor_reg + 1'b1;
                if (cursor_reg == last_reg) begin
                    state_next = SC_TAIL;
                end
            end
            SC_TAIL: begin
                state_next = SC_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SC_IDLE;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            first_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == SC_RUN);
            done_reg     <= done_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        cursor_reg  <= cursor_next;
        last_reg    <= last_next;
        min_reg     <= min_next;
        min_pos_reg <= min_pos_next;
        rd_pos_reg  <= cursor_reg;
        rd_data_reg <= hash_ring[cursor_reg[rhw_pkg::WIDX_W-1:0]];
        if (req.wr_en) begin
            hash_ring[req.wr_addr] <= req.wr_data;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.min_hash = min_reg;
    assign rsp.min_pos  = min_pos_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == SC_IDLE)
        else $error("scan start while busy");

    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !rd_valid_reg && state_reg == SC_IDLE)
        else $error("scan done with a read in flight");
`endif

endmodule

>>> sv/rolling_hash_winnowing_top.sv
// Rolling hash winnowing top level: sequencer, configuration, line state, output register.
// After a byte transfer within the line limit, s_ready stays low through the hash and decide
// states; a result adds the emit state, which waits out any output back-pressure, a rescan
// adds the scan state, and a line end adds the finish state. m_valid is set from the emit
// state through the output register. Synchronous active-low reset clears control state
// and sets kgram_length 5, window_size 4; the byte and hash rings need no clearing pass.
`timescale 1ns / 1ps

module rolling_hash_winnowing_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rhw_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rhw_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rhw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rhw_pkg::CFG_W-1:0]           cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_HASH   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [rhw_pkg::CFG_W-1:0]  kgram_reg, kgram_next;
    logic [rhw_pkg::CFG_W-1:0]  window_reg, window_next;
    logic [rhw_pkg::HASH_W-1:0] negw_reg, negw_next;
    logic [rhw_pkg::LINE_W-1:0] bil_reg, bil_next;
    logic [rhw_pkg::LCNT_W-1:0] lines_reg, lines_next;
    logic [rhw_pkg::HASH_W-1:0] min_hash_reg, min_hash_next;
    logic [rhw_pkg::POS_W-1:0]  min_pos_reg, min_pos_next;
    logic [rhw_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       last_reg, last_next;
    logic                       out_valid_reg, out_valid_next;
    rhw_pkg::out_item_t         out_data_reg, out_data_next;

    rhw_pkg::hash_req_t hash_req;
    rhw_pkg::hash_rsp_t hash_rsp;
    rhw_pkg::scan_req_t scan_req;
    rhw_pkg::scan_rsp_t scan_rsp;

    logic                       in_xfer;
    logic                       in_use;
    logic [rhw_pkg::CFG_W-1:0]  kc;
    logic [rhw_pkg::CFG_W-1:0]  wc;
    logic [rhw_pkg::CFG_W-1:0]  cfg_k;
    logic [rhw_pkg::LINE_W-1:0] pos_inc;
    logic [rhw_pkg::LINE_W-1:0] g_ext;
    logic [rhw_pkg::LINE_W-1:0] gp1;
    logic [rhw_pkg::LINE_W-1:0] lo_ext;
    logic [rhw_pkg::POS_W-1:0]  g;
    logic [rhw_pkg::POS_W-1:0]  lo;
    logic                       have_gram;
    logic                       out_free;

    assign kc    = rhw_pkg::clamp_size(kgram_reg, rhw_pkg::MAX_KGRAM);
    assign wc    = rhw_pkg::clamp_size(window_reg, rhw_pkg::MAX_WINDOW);
    assign cfg_k = rhw_pkg::clamp_size(cfg_data, rhw_pkg::MAX_KGRAM);

    assign s_ready   = (state_reg == ST_IDLE);
    // register writes only between bytes
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;
    assign in_xfer   = s_valid && s_ready;
    assign in_use    = (32'(bil_reg) < rhw_pkg::MAX_LINE);

    assign pos_inc   = rhw_pkg::LINE_W'(pos_reg) + 1'b1;
    assign have_gram = pos_inc >= rhw_pkg::LINE_W'(kc);
    assign g_ext     = pos_inc - rhw_pkg::LINE_W'(kc);
    assign g         = g_ext[rhw_pkg::POS_W-1:0];
    assign gp1       = g_ext + 1'b1;
    assign lo_ext    = gp1 - rhw_pkg::LINE_W'(wc);
    assign lo        = lo_ext[rhw_pkg::POS_W-1:0];
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        hash_req.start      = in_xfer && in_use;
        hash_req.clear      = (state_reg == ST_FINISH);
        hash_req.text_byte  = s_data.text_byte;
        hash_req.pos        = bil_reg[rhw_pkg::POS_W-1:0];
        hash_req.kgram      = kc;
        hash_req.neg_weight = negw_reg;
    end

    rhw_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hash_req),
        .rsp     (hash_rsp)
    );

    rhw_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scan_req),
        .rsp     (scan_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        kgram_next     = kgram_reg;
        window_next    = window_reg;
        negw_next      = negw_reg;
        bil_next       = bil_reg;
        lines_next     = lines_reg;
        min_hash_next  = min_hash_reg;
        min_pos_next   = min_pos_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        scan_req.start   = 1'b0;
        scan_req.first   = '0;
        scan_req.last    = g;
        scan_req.wr_en   = 1'b0;
        scan_req.wr_addr = g[rhw_pkg::WIDX_W-1:0];
        scan_req.wr_data = hash_rsp.hash;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == rhw_pkg::CFG_KGRAM_LENGTH) begin
                kgram_next = cfg_data;
                negw_next  = rhw_pkg::NEG_WEIGHT[rhw_pkg::KIDX_W'(cfg_k - 1'b1)];
            end else if (cfg_index == rhw_pkg::CFG_WINDOW_SIZE) begin
                window_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    last_next = s_data.line_end;
                    if (in_use) begin
                        pos_next   = bil_reg[rhw_pkg::POS_W-1:0];
                        bil_next   = bil_reg + 1'b1;
                        state_next = ST_HASH;
                    end else if (s_data.line_end) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_HASH: begin
                if (hash_rsp.done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = last_reg ? ST_FINISH : ST_IDLE;
                if (have_gram) begin
                    scan_req.wr_en = 1'b1;
                    if (gp1 == rhw_pkg::LINE_W'(wc)) begin
                        scan_req.start = 1'b1;
                        state_next     = ST_SCAN;
                    end else if (gp1 > rhw_pkg::LINE_W'(wc)) begin
                        if (min_pos_reg < lo) begin
                            scan_req.start = 1'b1;
                            scan_req.first = lo;
                            state_next     = ST_SCAN;
                        end else if (hash_rsp.hash <= min_hash_reg) begin
                            min_hash_next = hash_rsp.hash;
                            min_pos_next  = g;
                            state_next    = ST_EMIT;
                        end
                    end else if (last_reg) begin
                        // short line: partial window closes at line end
                        scan_req.start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    min_hash_next = scan_rsp.min_hash;
                    min_pos_next  = scan_rsp.min_pos;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.fingerprint   = min_hash_reg;
                    out_data_next.gram_position = min_pos_reg;
                    out_data_next.line_number   = lines_reg;
                    state_next                  = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                bil_next = '0;
                if (lines_reg != '1) begin
                    lines_next = lines_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kgram_reg     <= rhw_pkg::DEFAULT_KGRAM;
            window_reg    <= rhw_pkg::DEFAULT_WINDOW;
            negw_reg      <= rhw_pkg::NEG_WEIGHT[rhw_pkg::KIDX_W'(rhw_pkg::DEFAULT_KGRAM - 1'b1)];
            bil_reg       <= '0;
            lines_reg     <= '0;
            min_hash_reg  <= '0;
            min_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kgram_reg     <= kgram_next;
            window_reg    <= window_next;
            negw_reg      <= negw_next;
            bil_reg       <= bil_next;
            lines_reg     <= lines_next;
            min_hash_reg  <= min_hash_next;
            min_pos_reg   <= min_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_busy_after_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && in_use) |=> !s_ready)
        else $error("ready right after a byte transfer");

    a_hash_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_rsp.done |-> state_reg == ST_HASH)
        else $error("hash done outside hash wait");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(bil_reg) <= rhw_pkg::MAX_LINE)
        else $error("line byte count overflow");
`endif

endmodule

>>> tb/rolling_hash_winnowing_top_tb.sv
// Self-checking testbench for the rolling hash winnowing block: table and random byte streams.
`timescale 1ns / 1ps

module rolling_hash_winnowing_top_tb;

    localparam int unsigned SETTLE_CYCLES  = 100;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RING_FILL      = rhw_pkg::MAX_KGRAM;
    localparam int unsigned RANDOM_ITEMS   = 1780;

    localparam logic [rhw_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = rhw_pkg::CFG_WINDOW_SIZE + 1'b1;
    localparam logic [rhw_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = '1;

    typedef enum logic [1:0] {ROW_BYTE, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} row_chk_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [7:0]         arg;    // text byte, or register index
        logic [6:0]         val;    // line_end in bit 0, or register data
        row_chk_t           chk;
        rhw_pkg::out_item_t want;
    } dir_row_t;

    localparam rhw_pkg::out_item_t NO_RES = '0;
    localparam int DIR_ROWS = 31;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_BYTE, 8'd97,  7'd0, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd98,  7'd1, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd0,   7'd0, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd0,   7'd0, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd0,   7'd0, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd0,   7'd0, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd0,   7'd1, CHK_VALUE, '{7'd0, 12'd0, 16'd1}},
        '{ROW_REG,  8'(rhw_pkg::CFG_KGRAM_LENGTH), 7'd1, CHK_NONE, NO_RES},
        '{ROW_REG,  8'(rhw_pkg::CFG_WINDOW_SIZE),  7'd1, CHK_NONE, NO_RES},
        '{ROW_BYTE, 8'd0,   7'd0, CHK_VALUE, '{7'd0,   12'd0, 16'd2}},
        '{ROW_BYTE, 8'd255, 7'd0, CHK_VALUE, '{7'd53,  12'd1, 16'd2}},
        '{ROW_BYTE, 8'd100, 7'd0, CHK_VALUE, '{7'd100, 12'd2, 16'd2}},
        '{ROW_BYTE, 8'd128, 7'd1, CHK_VALUE, '{7'd27,  12'd3, 16'd2}},
        '{ROW_REG,  8'(rhw_pkg::CFG_KGRAM_LENGTH), 7'd0, CHK_NONE, NO_RES},
        '{ROW_REG,  8'(rhw_pkg::CFG_WINDOW_SIZE),  7'd0, CHK_NONE, NO_RES},
        '{ROW_BYTE, 8'd202, 7'd1, CHK_VALUE, '{7'd0, 12'd0, 16'd3}},
        '{ROW_REG,  8'(CFG_UNUSED_LO),             7'd9,   CHK_NONE, NO_RES},
        '{ROW_REG,  8'(CFG_UNUSED_HI),             7'd127, CHK_NONE, NO_RES},
        '{ROW_BYTE, 8'd1,   7'd1, CHK_VALUE, '{7'd1, 12'd0, 16'd4}},
        '{ROW_REG,  8'(rhw_pkg::CFG_KGRAM_LENGTH), 7'd127, CHK_NONE, NO_RES},
        '{ROW_REG,  8'(rhw_pkg::CFG_WINDOW_SIZE),  7'd127, CHK_NONE, NO_RES},
        '{ROW_BYTE, 8'd7,   7'd0, CHK_NONE,  NO_RES},
        '{ROW_BYTE, 8'd255, 7'd1, CHK_NONE,  NO_RES},
        '{ROW_REG,  8'(rhw_pkg::CFG_KGRAM_LENGTH), 7'd2, CHK_NONE, NO_RES},
        '{ROW_REG,  8'(rhw_pkg::CFG_WINDOW_SIZE),  7'd3, CHK_NONE, NO_RES},
        '{ROW_BYTE, 8'd255, 7'd0, CHK_MODEL, NO_RES},
        '{ROW_BYTE, 8'd0,   7'd0, CHK_MODEL, NO_RES},
        '{ROW_BYTE, 8'd255, 7'd0, CHK_MODEL, NO_RES},
        // k-gram grows in the middle of a line
        '{ROW_REG,  8'(rhw_pkg::CFG_KGRAM_LENGTH), 7'd3, CHK_NONE, NO_RES},
        '{ROW_BYTE, 8'd128, 7'd0, CHK_MODEL, NO_RES},
        '{ROW_BYTE, 8'd1,   7'd1, CHK_MODEL, NO_RES}
    };

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    rhw_pkg::in_item_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    rhw_pkg::out_item_t              m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rhw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rhw_pkg::CFG_W-1:0]       cfg_data  = '0;

    rolling_hash_winnowing_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // fingerprint predictor state
    logic [rhw_pkg::CFG_W-1:0]  kgram_reg  = rhw_pkg::DEFAULT_KGRAM;
    logic [rhw_pkg::CFG_W-1:0]  window_reg = rhw_pkg::DEFAULT_WINDOW;
    logic [rhw_pkg::BYTE_W-1:0] text_ring [rhw_pkg::MAX_KGRAM];
    logic [rhw_pkg::HASH_W-1:0] hash_hist [rhw_pkg::MAX_WINDOW];
    int unsigned                roll_hash  = 0;
    int unsigned                line_len   = 0;
    int unsigned                win_min    = 0;
    int unsigned                win_pos    = 0;
    int unsigned                lines_done = 0;

    rhw_pkg::out_item_t fp_expect_q [$];
    int unsigned        fails        = 0;
    int unsigned        random_items = 0;
    int unsigned        quiet_cycles = 0;
    bit                 tx_idle      = 1'b1;
    bit                 rx_idle      = 1'b1;

    function automatic int unsigned fit_size(input logic [rhw_pkg::CFG_W-1:0] v,
                                             input int unsigned top);
        if (v == '0) return 1;
        if (int'(v) > top) return top;
        return v;
    endfunction

    function automatic void rescan_window(input int unsigned first, input int unsigned last);
        win_min = 8'hFF;
        for (int unsigned j = first; j <= last; j++) begin
            if (hash_hist[j % rhw_pkg::MAX_WINDOW] <= win_min) begin
                win_min = hash_hist[j % rhw_pkg::MAX_WINDOW];
                win_pos = j;
            end
        end
    endfunction

    function automatic bit winnow_step(input rhw_pkg::in_item_t item,
                                       output rhw_pkg::out_item_t res);
        int unsigned k, w, pos, g, h, cnt, lead, old, line_at;
        bit got;
        k = fit_size(kgram_reg, rhw_pkg::MAX_KGRAM);
        w = fit_size(window_reg, rhw_pkg::MAX_WINDOW);
        pos = line_len;
        line_at = lines_done;
        got = 1'b0;
        res = '0;
        if (pos < rhw_pkg::MAX_LINE) begin
            if (pos < k) begin
                roll_hash = (roll_hash * rhw_pkg::HASH_BASE + item.text_byte) % rhw_pkg::HASH_MOD;
            end else begin
                lead = 1;
                for (int unsigned i = 1; i < k; i++) begin
                    lead = (lead * rhw_pkg::HASH_BASE) % rhw_pkg::HASH_MOD;
                end
                old = text_ring[(pos - k) % rhw_pkg::MAX_KGRAM];
                roll_hash = (roll_hash + rhw_pkg::HASH_MOD - (old * lead) % rhw_pkg::HASH_MOD)
                            % rhw_pkg::HASH_MOD;
                roll_hash = (roll_hash * rhw_pkg::HASH_BASE + item.text_byte) % rhw_pkg::HASH_MOD;
            end
            text_ring[pos % rhw_pkg::MAX_KGRAM] = item.text_byte;
            line_len = pos + 1;
            if (pos + 1 >= k) begin
                g = pos + 1 - k;
                h = roll_hash;
                hash_hist[g % rhw_pkg::MAX_WINDOW] = rhw_pkg::HASH_W'(h);
                if (g + 1 == w) begin
                    rescan_window(0, g);
                    got = 1'b1;
                end else if (g + 1 > w) begin
                    if (win_pos < g + 1 - w) begin
                        rescan_window(g + 1 - w, g);
                        got = 1'b1;
                    end else if (h <= win_min) begin
                        win_min = h;
                        win_pos = g;
                        got = 1'b1;
                    end
                end
            end
        end
        if (item.line_end) begin
            cnt = (line_len >= k) ? line_len + 1 - k : 0;
            if (cnt > 0 && cnt < w) begin
                rescan_window(0, cnt - 1);
                got = 1'b1;
            end
            line_len = 0;
            roll_hash = 0;
            if (lines_done < 16'hFFFF) lines_done++;
        end
        if (got) begin
            res.fingerprint   = rhw_pkg::HASH_W'(win_min);
            res.gram_position = rhw_pkg::POS_W'(win_pos);
            res.line_number   = rhw_pkg::LCNT_W'(line_at);
        end
        return got;
    endfunction

    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [rhw_pkg::CFG_W-1:0] extreme_size();
        case ($urandom_range(0, 5))
            0: return rhw_pkg::CFG_W'(0);
            1: return rhw_pkg::CFG_W'(1);
            2: return rhw_pkg::CFG_W'(rhw_pkg::MAX_KGRAM - 1);
            3: return rhw_pkg::CFG_W'(rhw_pkg::MAX_KGRAM);
            4: return rhw_pkg::CFG_W'(rhw_pkg::MAX_KGRAM + 1);
            default: return '1;
        endcase
    endfunction

    task automatic send_byte(input rhw_pkg::in_item_t item, input int unsigned gap,
                             input row_chk_t chk, input rhw_pkg::out_item_t want);
        rhw_pkg::out_item_t res;
        bit got;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = winnow_step(item, res);
        if (chk == CHK_VALUE) begin
            fp_expect_q = {fp_expect_q, want};
        end else if (chk == CHK_MODEL && got) begin
            fp_expect_q = {fp_expect_q, res};
        end
    endtask

    task automatic write_reg(input logic [rhw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rhw_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == rhw_pkg::CFG_KGRAM_LENGTH) begin
            kgram_reg = data;
        end else if (idx == rhw_pkg::CFG_WINDOW_SIZE) begin
            window_reg = data;
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender holds off until every expected fingerprint is out and the block has settled
    task automatic drain_block();
        s_valid <= 1'b0;
        while (fp_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase();
        int unsigned n_lines, len, span;
        bit cut_last, narrow;
        rhw_pkg::in_item_t item;
        drain_block();
        case ($urandom_range(0, 5))
            0: begin
                write_reg(rhw_pkg::CFG_KGRAM_LENGTH, rhw_pkg::CFG_W'($urandom_range(0, 127)));
                write_reg(rhw_pkg::CFG_WINDOW_SIZE, rhw_pkg::CFG_W'($urandom_range(0, 127)));
            end
            1: begin
                write_reg(rhw_pkg::CFG_KGRAM_LENGTH, extreme_size());
                write_reg(rhw_pkg::CFG_WINDOW_SIZE, extreme_size());
            end
            2: write_reg(($urandom_range(0, 1) != 0) ? rhw_pkg::CFG_KGRAM_LENGTH
                                                     : rhw_pkg::CFG_WINDOW_SIZE,
                         rhw_pkg::CFG_W'($urandom_range(1, 8)));
            3: write_reg(rhw_pkg::CFG_INDEX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                         rhw_pkg::CFG_W'($urandom));
            default: begin
                write_reg(rhw_pkg::CFG_KGRAM_LENGTH, rhw_pkg::CFG_W'($urandom_range(1, 8)));
                write_reg(rhw_pkg::CFG_WINDOW_SIZE, rhw_pkg::CFG_W'($urandom_range(1, 8)));
            end
        endcase
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        n_lines = $urandom_range(1, 8);
        cut_last = ($urandom_range(0, 3) == 0);
        for (int unsigned ln = 0; ln < n_lines; ln++) begin
            span = fit_size(kgram_reg, rhw_pkg::MAX_KGRAM)
                   + fit_size(window_reg, rhw_pkg::MAX_WINDOW) + 40;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : $urandom_range(1, 30);
            narrow = ($urandom_range(0, 4) == 0);
            for (int unsigned i = 0; i < len; i++) begin
                if (narrow) begin
                    item.text_byte = ($urandom_range(0, 1) != 0) ? 8'd101 : 8'd0;
                end else begin
                    item.text_byte = rhw_pkg::BYTE_W'($urandom);
                end
                item.line_end = (i == len - 1) && !(cut_last && ln == n_lines - 1);
                send_byte(item, pick_gap(tx_idle), CHK_MODEL, NO_RES);
                random_items++;
            end
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        rhw_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (fp_expect_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual fp %0d pos %0d line %0d",
                         $time, m_data.fingerprint, m_data.gram_position, m_data.line_number);
                fails++;
            end else begin
                want = fp_expect_q.pop_front();
                check_field("fingerprint", want.fingerprint, m_data.fingerprint);
                check_field("gram_position", want.gram_position, m_data.gram_position);
                check_field("line_number", want.line_number, m_data.line_number);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d fingerprints outstanding", $time,
                     fp_expect_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned gap;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = pick_gap(rx_idle);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        rhw_pkg::in_item_t item;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].kind == ROW_REG) begin
                drain_block();
                write_reg(rhw_pkg::CFG_INDEX_W'(DIR_TAB[i].arg), DIR_TAB[i].val);
            end else begin
                item.text_byte = DIR_TAB[i].arg;
                item.line_end  = DIR_TAB[i].val[0];
                send_byte(item, pick_gap(tx_idle), DIR_TAB[i].chk, DIR_TAB[i].want);
            end
        end

        // fills both rings before any mid-line shrink of the k-gram
        drain_block();
        write_reg(rhw_pkg::CFG_KGRAM_LENGTH, rhw_pkg::CFG_W'(1));
        write_reg(rhw_pkg::CFG_WINDOW_SIZE, rhw_pkg::CFG_W'(2));
        for (int unsigned i = 0; i < RING_FILL; i++) begin
            item.text_byte = rhw_pkg::BYTE_W'($urandom);
            item.line_end  = (i == RING_FILL - 1);
            send_byte(item, pick_gap(tx_idle), CHK_MODEL, NO_RES);
        end

        while (random_items < RANDOM_ITEMS) random_phase();

        drain_block();
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
